FILE: design/swsnd_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the sliding window sender
// no dependencies

package swsnd_pkg;

    localparam int MAX_SEQ_DEF      = 16;
    localparam int PAYLOAD_BITS_DEF = 32;

    localparam int SEQ_W = 4;
    localparam int MOD_W = 5;
    localparam int WIN_W = 4;
    localparam int CMD_W = 2;
    localparam int CFG_W = 5;

    localparam logic [CMD_W-1:0] CMD_SEND    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ACK     = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TIMEOUT = 2'd2;

    localparam logic CFG_WINDOW_SIZE = 1'b0;
    localparam logic CFG_SEQ_MODULUS = 1'b1;

    localparam logic [WIN_W-1:0] WINDOW_SIZE_RST = 4'd4;
    localparam logic [MOD_W-1:0] SEQ_MODULUS_RST = 5'd8;

    localparam logic [SEQ_W-1:0] DUP_TRIGGER = 4'd3;
    localparam logic [SEQ_W-1:0] DUP_MAX     = 4'd15;

    // request from the sequencer to the window control
    typedef struct packed {
        logic             load;
        logic             calc;
        logic [CMD_W-1:0] cmd;
        logic [SEQ_W-1:0] ack;
        logic             ack_ok;
    } win_ctl_t;

    // decisions of one command
    typedef struct packed {
        logic             acc;
        logic             txv;
        logic             retx;
        logic [SEQ_W-1:0] txs;
        logic             stp;
        logic [SEQ_W-1:0] stps;
        logic             sta;
        logic [SEQ_W-1:0] stas;
        logic             full;
    } step_res_t;

endpackage

FILE: design/swsnd_store.sv
`timescale 1ns / 1ps
// packet store: one write port, one registered read port
// depends on nothing

module swsnd_store #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/swsnd_window.sv
`timescale 1ns / 1ps
// window pointers, duplicate ack count and the command decisions
// depends on swsnd_pkg

module swsnd_window
    import swsnd_pkg::*;
#(
    parameter int MAX_SEQ = MAX_SEQ_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  win_ctl_t         ctl,
    input  logic [WIN_W-1:0] win_size,
    input  logic [MOD_W-1:0] seq_mod,
    output logic             busy,
    output step_res_t        res,
    output logic [MOD_W-1:0] op_addr
);

    logic [SEQ_W-1:0] base_reg, base_next;
    logic [SEQ_W-1:0] nxt_reg, nxt_next;
    logic [SEQ_W-1:0] outst_reg, outst_next;
    logic [SEQ_W-1:0] dup_reg, dup_next;
    logic [SEQ_W-1:0] ack_reg, ack_next;

    logic [MOD_W-1:0] m, m_minus1;
    logic [WIN_W-1:0] win;
    logic [MOD_W-1:0] b5, n5, a5;
    logic [MOD_W-1:0] b_sub, n_sub, a_sub;
    logic [MOD_W:0]   off_raw, off_sub;
    logic [MOD_W-1:0] off, off1;
    logic [MOD_W-1:0] a_inc, n_inc, b_prev;
    logic [MOD_W-1:0] base_after, nxt_after;
    logic [SEQ_W-1:0] outst_sub, dup_inc;
    logic             b_hi, n_hi, a_hi;

    always_comb begin
        if (seq_mod < MOD_W'(2)) begin
            m = MOD_W'(2);
        end else if (32'(seq_mod) > MAX_SEQ) begin
            m = MOD_W'(MAX_SEQ);
        end else begin
            m = seq_mod;
        end
    end

    assign m_minus1 = m - MOD_W'(1);
    assign win = ({1'b0, win_size} > m_minus1) ? m_minus1[WIN_W-1:0] : win_size;

    assign b5 = {1'b0, base_reg};
    assign n5 = {1'b0, nxt_reg};
    assign a5 = {1'b0, ack_reg};

    // pointers stale from a new modulus and acks drop below m one subtract a cycle
    assign b_hi  = (b5 >= m);
    assign n_hi  = (n5 >= m);
    assign a_hi  = (a5 >= m);
    assign b_sub = b5 - m;
    assign n_sub = n5 - m;
    assign a_sub = a5 - m;
    assign busy  = b_hi || n_hi || a_hi;

    assign off_raw = {1'b0, a5} + {1'b0, m} - {1'b0, b5};
    assign off_sub = off_raw - {1'b0, m};
    assign off     = (off_raw >= {1'b0, m}) ? off_sub[MOD_W-1:0] : off_raw[MOD_W-1:0];
    assign off1    = off + MOD_W'(1);

    assign a_inc      = a5 + MOD_W'(1);
    assign n_inc      = n5 + MOD_W'(1);
    assign base_after = (a_inc == m) ? '0 : a_inc;
    assign nxt_after  = (n_inc == m) ? '0 : n_inc;
    assign b_prev     = (b5 == '0) ? m_minus1 : (b5 - MOD_W'(1));
    assign outst_sub  = SEQ_W'({1'b0, outst_reg} - off1);
    assign dup_inc    = (dup_reg == DUP_MAX) ? DUP_MAX : (dup_reg + SEQ_W'(1));

    assign op_addr = (ctl.cmd == CMD_SEND) ? n5 : b5;

    always_comb begin
        base_next  = base_reg;
        nxt_next   = nxt_reg;
        outst_next = outst_reg;
        dup_next   = dup_reg;
        ack_next   = ack_reg;
        res        = '0;

        if (ctl.load) begin
            ack_next = ctl.ack;
        end else if (ctl.calc && busy) begin
            if (b_hi) base_next = b_sub[SEQ_W-1:0];
            if (n_hi) nxt_next  = n_sub[SEQ_W-1:0];
            if (a_hi) ack_next  = a_sub[SEQ_W-1:0];
        end else if (ctl.calc) begin
            case (ctl.cmd)
                CMD_SEND: begin
                    if (outst_reg < win) begin
                        res.acc = 1'b1;
                        res.txv = 1'b1;
                        res.txs = n5[SEQ_W-1:0];
                        if (outst_reg == '0) begin
                            res.sta  = 1'b1;
                            res.stas = n5[SEQ_W-1:0];
                        end
                        nxt_next   = nxt_after[SEQ_W-1:0];
                        outst_next = outst_reg + SEQ_W'(1);
                    end
                end
                CMD_ACK: begin
                    if (!ctl.ack_ok) begin
                        // bad checksum, dropped
                    end else if ({1'b0, outst_reg} > off) begin
                        res.stp    = 1'b1;
                        res.stps   = b5[SEQ_W-1:0];
                        base_next  = base_after[SEQ_W-1:0];
                        outst_next = outst_sub;
                        dup_next   = '0;
                        if (outst_sub != '0) begin
                            res.sta  = 1'b1;
                            res.stas = base_after[SEQ_W-1:0];
                        end
                    end else if (a5 == b_prev) begin
                        dup_next = dup_inc;
                        if (dup_inc == DUP_TRIGGER && outst_reg != '0) begin
                            res.txv  = 1'b1;
                            res.retx = 1'b1;
                            res.txs  = b5[SEQ_W-1:0];
                            dup_next = '0;
                        end
                    end
                end
                CMD_TIMEOUT: begin
                    if (outst_reg != '0) begin
                        res.stp  = 1'b1;
                        res.stps = b5[SEQ_W-1:0];
                        res.sta  = 1'b1;
                        res.stas = b5[SEQ_W-1:0];
                        res.txv  = 1'b1;
                        res.retx = 1'b1;
                        res.txs  = b5[SEQ_W-1:0];
                    end
                end
                default: begin
                end
            endcase
            res.full = (outst_next >= win);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg  <= '0;
            nxt_reg   <= '0;
            outst_reg <= '0;
            dup_reg   <= '0;
            ack_reg   <= '0;
        end else begin
            base_reg  <= base_next;
            nxt_reg   <= nxt_next;
            outst_reg <= outst_next;
            dup_reg   <= dup_next;
            ack_reg   <= ack_next;
        end
    end

endmodule

FILE: design/sliding_window_sender.sv
`timescale 1ns / 1ps
// Sender side of a sliding-window link: send, cumulative ack with fast
// retransmit on the third duplicate, and retransmit timeout.
//
// s_tuser carries the command, s_tdata the payload, ack number and checksum
// flag. Each accepted transaction yields exactly one result transaction on
// m_tdata: acceptance, the packet to transmit, the timer stop/start requests and window full.
// cfg_we/cfg_addr/cfg_wdata write window_size (0) and seq_modulus (1); write
// them only while no command is in flight.
//
// The command is registered when taken; in the calc state its decisions and the
// store read are registered, and in the finish state, once the output is free,
// the result. A new command is taken only when idle or in that finish state. A
// command whose ack field, or whose stale pointers after a modulus change, lie
// at or above the modulus stays in the calc state while the modulus is subtracted.
// The next command is taken while a result still waits in the output register;
// if m_tready stays low the block holds its result and stops taking input after
// one more command. Reset clears pointers, counts, state, configuration and valid;
// the packet store and the data registers are not cleared.

module sliding_window_sender
    import swsnd_pkg::*;
#(
    parameter int MAX_SEQ      = MAX_SEQ_DEF,
    parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF,
    localparam int IN_W  = ((PAYLOAD_BITS + 5 + 7) / 8) * 8,
    localparam int OUT_W = ((PAYLOAD_BITS + 17 + 7) / 8) * 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    // configuration write
    input  logic             cfg_we,
    input  logic             cfg_addr,
    input  logic [CFG_W-1:0] cfg_wdata,
    // command input
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,  // payload, ack_number, ack_checksum_ok
    input  logic [CMD_W-1:0] s_tuser,  // command
    // result output
    output logic             m_tvalid,
    input  logic             m_tready,
    // accepted, transmit_valid, transmit_seq, transmit_data, timer_stop,
    // stop_seq, timer_start, start_seq, window_full
    output logic [OUT_W-1:0] m_tdata
);

    localparam int AW = $clog2(MAX_SEQ);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CALC = 3'b010,
        ST_FIN  = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [WIN_W-1:0] win_size_reg;
    logic [MOD_W-1:0] seq_mod_reg;

    logic [CMD_W-1:0]        cmd_reg;
    logic [PAYLOAD_BITS-1:0] payload_reg;
    logic                    ack_ok_reg;
    step_res_t               res_reg;

    logic             m_tvalid_reg;
    logic [OUT_W-1:0] m_tdata_reg;

    win_ctl_t         ctl;
    step_res_t        res;
    logic             busy;
    logic [MOD_W-1:0] op_addr;
    logic [PAYLOAD_BITS-1:0] rdata, txd;
    logic             out_free, in_acc, finish, mem_we, mem_re;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = aresetn &&
                      ((state_reg == ST_IDLE) || ((state_reg == ST_FIN) && out_free));
    assign in_acc   = s_tvalid && s_tready;
    assign finish   = (state_reg == ST_FIN) && out_free;

    assign ctl.load   = in_acc;
    assign ctl.calc   = (state_reg == ST_CALC);
    assign ctl.cmd    = cmd_reg;
    assign ctl.ack    = s_tdata[PAYLOAD_BITS +: SEQ_W];
    assign ctl.ack_ok = ack_ok_reg;

    swsnd_window #(
        .MAX_SEQ(MAX_SEQ)
    ) u_window (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (ctl),
        .win_size (win_size_reg),
        .seq_mod  (seq_mod_reg),
        .busy     (busy),
        .res      (res),
        .op_addr  (op_addr)
    );

    // a send writes its entry one command ahead of any read of it, so no forwarding
    assign mem_we = ctl.calc && !busy && res.acc;
    assign mem_re = ctl.calc && !busy;

    swsnd_store #(
        .DEPTH(MAX_SEQ),
        .WIDTH(PAYLOAD_BITS)
    ) u_store (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (AW'(op_addr)),
        .wdata (payload_reg),
        .re    (mem_re),
        .raddr (AW'(op_addr)),
        .rdata (rdata)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_acc) state_next = ST_CALC;
            end
            ST_CALC: begin
                if (!busy) state_next = ST_FIN;
            end
            ST_FIN: begin
                if (finish) state_next = in_acc ? ST_CALC : ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        if (res_reg.retx) begin
            txd = rdata;
        end else if (res_reg.acc) begin
            txd = payload_reg;
        end else begin
            txd = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            win_size_reg <= WINDOW_SIZE_RST;
            seq_mod_reg  <= SEQ_MODULUS_RST;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                case (cfg_addr)
                    CFG_WINDOW_SIZE: win_size_reg <= cfg_wdata[WIN_W-1:0];
                    CFG_SEQ_MODULUS: seq_mod_reg  <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
            if (finish) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            cmd_reg     <= s_tuser;
            payload_reg <= s_tdata[PAYLOAD_BITS-1:0];
            ack_ok_reg  <= s_tdata[PAYLOAD_BITS + SEQ_W];
        end
        if (mem_re) begin
            res_reg <= res;
        end
        if (finish) begin
            m_tdata_reg <= OUT_W'({res_reg.full, res_reg.stas, res_reg.sta, res_reg.stps,
                                   res_reg.stp, txd, res_reg.txs, res_reg.txv,
                                   res_reg.acc});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

FILE: test/tb_sliding_window_sender.sv
`timescale 1ns / 1ps
// self-checking testbench for sliding_window_sender: directed and random command streams
// over several window and modulus settings, checked against an in-bench window predictor
// depends on swsnd_pkg and sliding_window_sender

module tb_sliding_window_sender;
    import swsnd_pkg::*;

    localparam int LIMIT       = 300000;
    localparam int HOLD_CYCLES = 150;
    localparam int IDLE_PAUSE  = 12;
    localparam int MAX_PRINT   = 50;
    localparam int EXP_DEPTH   = 16;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct {
        logic [CMD_W-1:0] cmd;
        logic [31:0]      payload;
        logic [3:0]       ack;
        logic             ok;
    } command_t;

    // result transaction, msb first
    typedef struct packed {
        logic [6:0]  pad;
        logic        window_full;
        logic [3:0]  start_seq;
        logic        timer_start;
        logic [3:0]  stop_seq;
        logic        timer_stop;
        logic [31:0] tx_data;
        logic [3:0]  tx_seq;
        logic        tx_valid;
        logic        accepted;
    } tx_result_t;

    class window_scoreboard;
        logic [3:0]  win_reg;
        logic [4:0]  mod_reg;
        int unsigned base, nxt, outst, dups;
        logic [31:0] store [MAX_SEQ_DEF];
        tx_result_t  expected_buf [EXP_DEPTH];
        int unsigned wr_count, rd_count;
        int unsigned fail_count, checked;
        int unsigned sends, refused, acks, timeouts, others, resends;

        function new();
            win_reg = WINDOW_SIZE_RST;
            mod_reg = SEQ_MODULUS_RST;
            base = 0;
            nxt = 0;
            outst = 0;
            dups = 0;
            foreach (store[i]) store[i] = '0;
            wr_count = 0;
            rd_count = 0;
            fail_count = 0;
            checked = 0;
            sends = 0;
            refused = 0;
            acks = 0;
            timeouts = 0;
            others = 0;
            resends = 0;
        endfunction

        function int unsigned pending();
            return wr_count - rd_count;
        endfunction

        function int unsigned modulus();
            if (mod_reg < 2) return 2;
            if (mod_reg > MAX_SEQ_DEF) return MAX_SEQ_DEF;
            return 32'(mod_reg);
        endfunction

        function int unsigned window(int unsigned m);
            return (32'(win_reg) > m - 1) ? m - 1 : 32'(win_reg);
        endfunction

        function void write_reg(logic addr, logic [CFG_W-1:0] value);
            if (addr == CFG_WINDOW_SIZE) win_reg = value[3:0];
            else mod_reg = value;
        endfunction

        function void note_command(command_t c);
            int unsigned m, w, b, n, ack, off;
            tx_result_t r;
            m = modulus();
            w = window(m);
            b = base % m;
            n = nxt % m;
            r = '0;
            case (c.cmd)
                CMD_SEND: begin
                    sends++;
                    if (outst < w) begin
                        store[n] = c.payload;
                        r.accepted = 1'b1;
                        r.tx_valid = 1'b1;
                        r.tx_seq = 4'(n);
                        r.tx_data = c.payload;
                        if (outst == 0) begin
                            r.timer_start = 1'b1;
                            r.start_seq = 4'(n);
                        end
                        n = (n + 1) % m;
                        outst++;
                    end else begin
                        refused++;
                    end
                end
                CMD_ACK: begin
                    acks++;
                    ack = 32'(c.ack) % m;
                    off = (ack + m - b) % m;
                    if (!c.ok) begin
                        // corrupted ack is dropped
                    end else if (off < outst) begin
                        r.timer_stop = 1'b1;
                        r.stop_seq = 4'(b);
                        b = (ack + 1) % m;
                        outst = outst - (off + 1);
                        dups = 0;
                        if (outst != 0) begin
                            r.timer_start = 1'b1;
                            r.start_seq = 4'(b);
                        end
                    end else if (ack == (b + m - 1) % m) begin
                        if (dups < 32'(DUP_MAX)) dups++;
                        if (dups == 32'(DUP_TRIGGER) && outst > 0) begin
                            r.tx_valid = 1'b1;
                            r.tx_seq = 4'(b);
                            r.tx_data = store[b];
                            dups = 0;
                            resends++;
                        end
                    end
                end
                CMD_TIMEOUT: begin
                    timeouts++;
                    if (outst > 0) begin
                        r.timer_stop = 1'b1;
                        r.stop_seq = 4'(b);
                        r.timer_start = 1'b1;
                        r.start_seq = 4'(b);
                        r.tx_valid = 1'b1;
                        r.tx_seq = 4'(b);
                        r.tx_data = store[b];
                        resends++;
                    end
                end
                default: others++;
            endcase
            base = b;
            nxt = n;
            r.window_full = (outst >= w);
            expected_buf[wr_count % EXP_DEPTH] = r;
            wr_count++;
        endfunction

        task report(string msg);
            fail_count++;
            if (fail_count <= MAX_PRINT) $display("[%0t] error: %s", $time, msg);
        endtask

        task field_check(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report($sformatf("result %0d field %s got 0x%0h expected 0x%0h",
                                 checked, name, got, want));
        endtask

        task check_result(logic [55:0] raw);
            tx_result_t got, want;
            got = tx_result_t'(raw);
            if (pending() == 0) begin
                report($sformatf("result 0x%0h with nothing expected", raw));
                return;
            end
            want = expected_buf[rd_count % EXP_DEPTH];
            rd_count++;
            field_check("accepted", 32'(got.accepted), 32'(want.accepted));
            field_check("transmit_valid", 32'(got.tx_valid), 32'(want.tx_valid));
            field_check("transmit_seq", 32'(got.tx_seq), 32'(want.tx_seq));
            field_check("transmit_data", got.tx_data, want.tx_data);
            field_check("timer_stop", 32'(got.timer_stop), 32'(want.timer_stop));
            field_check("stop_seq", 32'(got.stop_seq), 32'(want.stop_seq));
            field_check("timer_start", 32'(got.timer_start), 32'(want.timer_start));
            field_check("start_seq", 32'(got.start_seq), 32'(want.start_seq));
            field_check("window_full", 32'(got.window_full), 32'(want.window_full));
            field_check("padding", 32'(got.pad), 32'(want.pad));
            checked++;
        endtask
    endclass

    logic             aclk      = 1'b0;
    logic             aresetn   = 1'b0;
    logic             cfg_we    = 1'b0;
    logic             cfg_addr  = 1'b0;
    logic [CFG_W-1:0] cfg_wdata = '0;
    logic             s_tvalid  = 1'b0;
    logic             s_tready;
    logic [39:0]      s_tdata   = '0;
    logic [CMD_W-1:0] s_tuser   = '0;
    logic             m_tvalid;
    logic             m_tready  = 1'b0;
    logic [55:0]      m_tdata;

    window_scoreboard sb = new();
    int unsigned cycle_count = 0;
    int unsigned item_count  = 0;
    int unsigned settings    = 0;
    int unsigned holds_done  = 0;
    bit          tx_burst    = 1'b0;
    bit          rx_burst    = 1'b0;
    bit          rx_hold     = 1'b0;

    sliding_window_sender u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // payload, ack_number, ack_checksum_ok
        .s_tuser   (s_tuser),   // command
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        // accepted, transmit_valid, transmit_seq, transmit_data, timer_stop,
        // stop_seq, timer_start, start_seq, window_full
        .m_tdata   (m_tdata)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT) begin
            $display("[%0t] timeout with %0d results outstanding", $time, sb.pending());
            $display("FAIL sliding_window_sender");
            $finish;
        end
    end

    // offer one command and wait for its transaction
    task automatic drive_cmd(input logic [CMD_W-1:0] cmd, input logic [31:0] payload,
                             input logic [3:0] ack, input logic ok);
        int unsigned gap;
        command_t c;
        c.cmd = cmd;
        c.payload = payload;
        c.ack = ack;
        c.ok = ok;
        gap = tx_burst ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {3'b000, ok, ack, payload};
        do @(posedge aclk); while (!s_tready);
        sb.note_command(c);
        item_count++;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (IDLE_PAUSE) @(posedge aclk);
    endtask

    // the sequence number just below the window base
    function automatic logic [3:0] below_base();
        int unsigned m;
        m = sb.modulus();
        return 4'((sb.base % m + m - 1) % m);
    endfunction

    // same ack modulo the modulus, sometimes with high bits that must be reduced away
    function automatic logic [3:0] alias_ack(int unsigned a, int unsigned m);
        return 4'(a + m * $urandom_range(0, (15 - a) / m));
    endfunction

    // modulus is only changed on an empty window so no unwritten slot is ever read
    task automatic set_config(input logic [3:0] win, input logic [CFG_W-1:0] modv);
        int unsigned m;
        wait_idle();
        if (modv != sb.mod_reg && sb.outst != 0) begin
            m = sb.modulus();
            drive_cmd(CMD_ACK, $urandom, 4'((sb.nxt % m + m - 1) % m), 1'b1);
            wait_idle();
        end
        cfg_we <= 1'b1;
        cfg_addr <= CFG_SEQ_MODULUS;
        cfg_wdata <= modv;
        @(posedge aclk);
        sb.write_reg(CFG_SEQ_MODULUS, modv);
        cfg_addr <= CFG_WINDOW_SIZE;
        cfg_wdata <= {1'b0, win};
        @(posedge aclk);
        sb.write_reg(CFG_WINDOW_SIZE, {1'b0, win});
        cfg_we <= 1'b0;
        @(posedge aclk);
        settings++;
    endtask

    task automatic random_item();
        int unsigned m, pick, a;
        logic [31:0] data;
        if (item_count % 24 == 0) tx_burst = ($urandom_range(0, 3) == 0);
        m = sb.modulus();
        pick = $urandom_range(0, 99);
        case ($urandom_range(0, 7))
            0: data = '0;
            1: data = '1;
            default: data = $urandom;
        endcase
        if (pick < 45) begin
            drive_cmd(CMD_SEND, data, 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
        end else if (pick < 70) begin
            a = (sb.outst == 0) ? $urandom_range(0, m - 1)
                                : (sb.base % m + $urandom_range(0, sb.outst - 1)) % m;
            drive_cmd(CMD_ACK, data, alias_ack(a, m), 1'b1);
        end else if (pick < 80) begin
            // duplicate run toward fast retransmit
            repeat ($urandom_range(1, 4))
                drive_cmd(CMD_ACK, data, alias_ack(32'(below_base()), m), 1'b1);
        end else if (pick < 88) begin
            drive_cmd(CMD_TIMEOUT, data, 4'($urandom_range(0, 15)),
                      1'($urandom_range(0, 1)));
        end else begin
            drive_cmd(2'($urandom_range(0, 3)), data, 4'($urandom_range(0, 15)),
                      1'($urandom_range(0, 1)));
        end
    endtask

    task automatic run_phase(input logic [3:0] win, input logic [CFG_W-1:0] modv,
                             input int unsigned n);
        set_config(win, modv);
        repeat (n) random_item();
    endtask

    // result side: random stalls, bursts, and one long hold-off on request
    initial begin
        int unsigned stall;
        int unsigned taken;
        taken = 0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (rx_hold) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                rx_hold = 1'b0;
                holds_done++;
            end
            if (taken % 32 == 0) rx_burst = ($urandom_range(0, 3) == 0);
            stall = rx_burst ? 0 : $urandom_range(0, 17);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            sb.check_result(m_tdata);
            taken++;
        end
    end

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: window 4, modulus 8
        drive_cmd(CMD_TIMEOUT, 32'h0, 4'd0, 1'b0);         // timeout on empty window
        drive_cmd(CMD_ACK, 32'h0, 4'd7, 1'b1);             // duplicate while empty
        drive_cmd(CMD_SEND, 32'h0000_0000, 4'd0, 1'b0);
        drive_cmd(CMD_SEND, 32'hffff_ffff, 4'd15, 1'b1);
        drive_cmd(CMD_SEND, 32'ha5a5_a5a5, 4'd0, 1'b0);
        drive_cmd(CMD_SEND, 32'h5a5a_5a5a, 4'd0, 1'b0);    // window now full
        drive_cmd(CMD_SEND, 32'h1234_5678, 4'd0, 1'b0);    // refused
        drive_cmd(CMD_ACK, 32'h0, 4'd0, 1'b0);             // bad checksum
        drive_cmd(CMD_UNUSED, 32'hffff_ffff, 4'd15, 1'b1); // unknown command
        drive_cmd(CMD_ACK, 32'h0, 4'd0, 1'b1);             // slide base by one
        repeat (3) drive_cmd(CMD_ACK, 32'h0, 4'd0, 1'b1);  // third duplicate resends
        drive_cmd(CMD_TIMEOUT, 32'h0, 4'd0, 1'b0);
        drive_cmd(CMD_ACK, 32'h0, 4'd15, 1'b1);            // outside window, not base-1
        drive_cmd(CMD_ACK, 32'h0, 4'd8, 1'b1);             // aliases to base-1
        drive_cmd(CMD_ACK, 32'h0, 4'd3, 1'b1);             // drains the window
        drive_cmd(CMD_ACK, 32'h0, 4'd3, 1'b1);
        drive_cmd(CMD_TIMEOUT, 32'hffff_ffff, 4'd15, 1'b1);
        drive_cmd(CMD_UNUSED, 32'h0, 4'd0, 1'b0);

        // smallest setting; duplicate count saturates on an empty window
        set_config(4'd1, 5'd2);
        repeat (17) drive_cmd(CMD_ACK, $urandom, below_base(), 1'b1);
        drive_cmd(CMD_SEND, $urandom, 4'd0, 1'b0);
        repeat (3) drive_cmd(CMD_ACK, $urandom, below_base(), 1'b1);
        repeat (40) random_item();

        // largest setting with the result side held off
        set_config(4'd15, 5'd16);
        tx_burst = 1'b1;
        rx_hold = 1'b1;
        repeat (40) drive_cmd(CMD_SEND, $urandom, 4'd0, 1'b0);
        repeat (40) random_item();

        // window above modulus-1, then fill it and shrink it to leave it overfull
        run_phase(4'd15, 5'd8, 40);
        while (sb.outst < sb.window(sb.modulus())) drive_cmd(CMD_SEND, $urandom, 4'd0, 1'b0);
        run_phase(4'd2, 5'd8, 40);

        run_phase(4'd0, 5'd8, 30);     // every send refused
        run_phase(4'd7, 5'd0, 40);     // modulus clamps up
        run_phase(4'd9, 5'd1, 30);
        run_phase(4'd15, 5'd31, 40);   // modulus clamps down
        run_phase(4'd5, 5'd17, 50);
        run_phase(4'd3, 5'd11, 50);
        run_phase(4'd6, 5'd7, 50);
        repeat (3) run_phase(4'($urandom_range(0, 15)), 5'($urandom_range(0, 31)), 30);

        wait_idle();
        repeat (10) @(posedge aclk);
        $display("covered %0d commands: %0d sends (%0d refused), %0d acks, %0d timeouts, %0d other",
                 item_count, sb.sends, sb.refused, sb.acks, sb.timeouts, sb.others);
        $display("%0d results checked, %0d resends, %0d register settings, %0d long hold-offs",
                 sb.checked, sb.resends, settings, holds_done);
        if (sb.fail_count == 0) begin
            $display("PASS sliding_window_sender");
        end else begin
            $display("%0d mismatches", sb.fail_count);
            $display("FAIL sliding_window_sender");
        end
        $finish;
    end

endmodule

FILE: sim.f
design/swsnd_pkg.sv
design/swsnd_store.sv
design/swsnd_window.sv
design/sliding_window_sender.sv
test/tb_sliding_window_sender.sv
